FILE: design/sscr_pkg.sv
// Shared constants and types for the square sound channel register block.
package sscr_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [15:0] A_NR10 = 16'hFF10;
  localparam logic [15:0] A_NR11 = 16'hFF11;
  localparam logic [15:0] A_NR12 = 16'hFF12;
  localparam logic [15:0] A_NR13 = 16'hFF13;
  localparam logic [15:0] A_NR14 = 16'hFF14;
  localparam logic [15:0] A_NR21 = 16'hFF16;
  localparam logic [15:0] A_NR22 = 16'hFF17;
  localparam logic [15:0] A_NR23 = 16'hFF18;
  localparam logic [15:0] A_NR24 = 16'hFF19;
  localparam logic [15:0] A_NR30 = 16'hFF1A;
  localparam logic [15:0] A_NR31 = 16'hFF1B;
  localparam logic [15:0] A_NR32 = 16'hFF1C;
  localparam logic [15:0] A_NR33 = 16'hFF1D;
  localparam logic [15:0] A_NR34 = 16'hFF1E;
  localparam logic [15:0] A_NR41 = 16'hFF20;
  localparam logic [15:0] A_NR42 = 16'hFF21;
  localparam logic [15:0] A_NR43 = 16'hFF22;
  localparam logic [15:0] A_NR44 = 16'hFF23;
  localparam logic [15:0] A_NR50 = 16'hFF24;
  localparam logic [15:0] A_NR51 = 16'hFF25;
  localparam logic [15:0] A_NR52 = 16'hFF26;
  localparam logic [15:0] A_WAVE = 16'hFF30;

  localparam logic [14:0] SWEEP_PERIOD = 15'd8192;
  localparam logic [15:0] ENV_PERIOD   = 16'd16384;
  localparam logic [13:0] LEN_PERIOD   = 14'd4096;

  // Registered input item.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [9:0]  clocks;
  } item_t;

  // State of one square channel.
  typedef struct packed {
    logic [10:0] freq;
    logic [6:0]  length;
    logic [1:0]  duty;
    logic [7:0]  env_set;
    logic [7:0]  env_cnt;
    logic [3:0]  volume;
    logic        en;
    logic        cnt;
    logic        trig;
  } sq_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  rdata;
    logic        ch1_active;
    logic [10:0] ch1_freq;
    logic [3:0]  ch1_volume;
    logic [1:0]  ch1_duty;
    logic        ch2_active;
    logic [10:0] ch2_freq;
    logic [3:0]  ch2_volume;
    logic [1:0]  ch2_duty;
  } res_t;

endpackage

FILE: design/square_sound_channel_registers.sv
// Top level of the square sound channel register block.
// Sound register block with two square channels. Each item is a bus write, a
// bus read or a tick of elapsed machine clocks. An accepted item is held in an
// input register; once the output register is free or draining, the register
// state updates and the result item is captured in an output register. One
// item is taken per clock when the output side keeps up: the input register
// refills in the same cycle its item moves to the output register, so
// throughput is one item per cycle. Ticks run the sweep, envelope and length
// frame timers; the envelope one fires past its period, the others on reaching it.
module square_sound_channel_registers
  import sscr_pkg::*;
#(
  parameter int WAVE_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_wdata,
  input  logic [9:0]  in_clocks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_rdata,
  output logic        out_ch1_active,
  output logic [10:0] out_ch1_freq,
  output logic [3:0]  out_ch1_volume,
  output logic [1:0]  out_ch1_duty,
  output logic        out_ch2_active,
  output logic [10:0] out_ch2_freq,
  output logic [3:0]  out_ch2_volume,
  output logic [1:0]  out_ch2_duty
);

  item_t item_r;
  logic  item_vld_r;
  res_t  res, res_r;
  logic  go;

  // The held item is executed when the output register is free or draining.
  assign go       = item_vld_r && (!out_valid || out_ready);
  assign in_ready = !item_vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) item_vld_r <= in_valid;
      if (go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= '{cmd: in_cmd, addr: in_addr,
                                         wdata: in_wdata, clocks: in_clocks};
    if (go) res_r <= res;
  end

  sscr_core #(.WAVE_BYTES(WAVE_BYTES)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item_r),
    .res   (res)
  );

  assign out_rdata      = res_r.rdata;
  assign out_ch1_active = res_r.ch1_active;
  assign out_ch1_freq   = res_r.ch1_freq;
  assign out_ch1_volume = res_r.ch1_volume;
  assign out_ch1_duty   = res_r.ch1_duty;
  assign out_ch2_active = res_r.ch2_active;
  assign out_ch2_freq   = res_r.ch2_freq;
  assign out_ch2_volume = res_r.ch2_volume;
  assign out_ch2_duty   = res_r.ch2_duty;

endmodule

FILE: design/sscr_core.sv
// Register state and next-state logic for one item.
module sscr_core
  import sscr_pkg::*;
#(
  parameter int WAVE_BYTES = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  go,
  input  item_t item,
  output res_t  res
);

  localparam int WAW = $clog2(WAVE_BYTES);

  logic [12:0] len_acc_r, len_acc_nxt;
  logic [13:0] swp_acc_r, swp_acc_nxt;
  logic [14:0] env_acc_r, env_acc_nxt;
  logic [5:0]  swp_set_r, swp_set_nxt;
  logic [7:0]  swp_cnt_r, swp_cnt_nxt;
  sq_t         sq_r [2];
  sq_t         sq_nxt [2];
  logic [23:0] wave_regs_r, wave_regs_nxt;
  logic [23:0] noise_regs_r, noise_regs_nxt;
  logic [16:0] mix_r, mix_nxt;
  logic [7:0]  wave_mem_r [WAVE_BYTES];
  logic [7:0]  rd;

  logic        in_wave;
  logic [WAW-1:0] wave_idx;
  logic [15:0] wave_off;

  assign wave_off = item.addr - A_WAVE;
  assign in_wave  = (item.addr >= A_WAVE) && (wave_off < 16'(WAVE_BYTES));
  assign wave_idx = wave_off[WAW-1:0];

  always_comb begin
    logic [13:0] la;
    logic [14:0] sa;
    logic [15:0] ea;
    logic [11:0] f;
    logic [10:0] d;
    sq_t s;
    len_acc_nxt    = len_acc_r;
    swp_acc_nxt    = swp_acc_r;
    env_acc_nxt    = env_acc_r;
    swp_set_nxt    = swp_set_r;
    swp_cnt_nxt    = swp_cnt_r;
    sq_nxt[0]      = sq_r[0];
    sq_nxt[1]      = sq_r[1];
    wave_regs_nxt  = wave_regs_r;
    noise_regs_nxt = noise_regs_r;
    mix_nxt        = mix_r;
    rd             = 8'd0;
    la = 14'd0; sa = 15'd0; ea = 16'd0; f = 12'd0; d = 11'd0; s = sq_r[0];
    case (item.cmd)
      CMD_WRITE: begin
        case (item.addr)
          A_NR10: begin
            swp_set_nxt = {item.wdata[6:4], item.wdata[3], item.wdata[1:0]};
            swp_cnt_nxt = 8'd0;
          end
          A_NR11: begin
            sq_nxt[0].length = {1'b0, item.wdata[5:0]};
            sq_nxt[0].duty = item.wdata[7:6];
          end
          A_NR21: begin
            sq_nxt[1].length = {1'b0, item.wdata[5:0]};
            sq_nxt[1].duty = item.wdata[7:6];
          end
          A_NR12: begin
            sq_nxt[0].env_set = item.wdata;
            sq_nxt[0].env_cnt = 8'd0;
          end
          A_NR22: begin
            sq_nxt[1].env_set = item.wdata;
            sq_nxt[1].env_cnt = 8'd0;
          end
          A_NR13: sq_nxt[0].freq[7:0] = item.wdata;
          A_NR23: sq_nxt[1].freq[7:0] = item.wdata;
          A_NR14, A_NR24: begin
            s = (item.addr == A_NR14) ? sq_r[0] : sq_r[1];
            s.freq[10:8] = item.wdata[2:0];
            s.cnt  = item.wdata[6];
            s.trig = 1'b0;
            if (item.wdata[7]) begin
              s.trig = 1'b1;
              s.en = 1'b1;
              if (s.length == 7'd0) s.length = 7'd64;
              s.volume = s.env_set[7:4];
              s.env_cnt = 8'd0;
            end
            if (item.addr == A_NR14) sq_nxt[0] = s;
            else sq_nxt[1] = s;
          end
          A_NR30: wave_regs_nxt[0] = item.wdata[7];
          A_NR31: wave_regs_nxt[8:1] = item.wdata;
          A_NR32: wave_regs_nxt[10:9] = item.wdata[6:5];
          A_NR33: wave_regs_nxt[18:11] = item.wdata;
          A_NR34: wave_regs_nxt[23:19] = {item.wdata[7:6], item.wdata[2:0]};
          A_NR41: noise_regs_nxt[5:0] = item.wdata[5:0];
          A_NR42: noise_regs_nxt[13:6] = item.wdata;
          A_NR43: noise_regs_nxt[21:14] = item.wdata;
          A_NR44: noise_regs_nxt[23:22] = item.wdata[7:6];
          A_NR50: mix_nxt[7:0] = item.wdata;
          A_NR51: mix_nxt[15:8] = item.wdata;
          A_NR52: mix_nxt[16] = item.wdata[7];
          default: ;
        endcase
      end
      CMD_READ: begin
        case (item.addr)
          A_NR10: rd = {1'b0, swp_set_r[5:3], swp_set_r[2], 1'b0, swp_set_r[1:0]};
          A_NR11: rd = {sq_r[0].duty, 6'd0};
          A_NR21: rd = {sq_r[1].duty, 6'd0};
          A_NR12: rd = sq_r[0].env_set;
          A_NR22: rd = sq_r[1].env_set;
          A_NR13: rd = sq_r[0].freq[7:0];
          A_NR23: rd = sq_r[1].freq[7:0];
          A_NR14: rd = {1'b0, sq_r[0].cnt, 6'd0};
          A_NR24: rd = {1'b0, sq_r[1].cnt, 6'd0};
          A_NR30: rd = {wave_regs_r[0], 7'd0};
          A_NR31: rd = wave_regs_r[8:1];
          A_NR32: rd = {1'b0, wave_regs_r[10:9], 5'd0};
          A_NR33: rd = wave_regs_r[18:11];
          A_NR34: rd = {1'b0, wave_regs_r[22], 6'd0};
          A_NR41: rd = {2'd0, noise_regs_r[5:0]};
          A_NR42: rd = noise_regs_r[13:6];
          A_NR43: rd = noise_regs_r[21:14];
          A_NR44: rd = {1'b0, noise_regs_r[22], 6'd0};
          A_NR50: rd = mix_r[7:0];
          A_NR51: rd = mix_r[15:8];
          A_NR52: rd = {mix_r[16], 5'd0, sq_r[1].en, sq_r[0].en};
          default: if (in_wave) rd = wave_mem_r[wave_idx];
        endcase
      end
      CMD_TICK: begin
        la = {1'b0, len_acc_r} + 14'(item.clocks);
        sa = {1'b0, swp_acc_r} + 15'(item.clocks);
        ea = {1'b0, env_acc_r} + 16'(item.clocks);
        // A pending trigger re-enables a channel that was shut off.
        for (int c = 0; c < 2; c++) begin
          if (!sq_nxt[c].en && sq_nxt[c].trig) begin
            sq_nxt[c].en = 1'b1;
            sq_nxt[c].trig = 1'b0;
          end
        end
        if (sa >= SWEEP_PERIOD) begin
          sa = sa - SWEEP_PERIOD;
          swp_cnt_nxt = swp_cnt_r + 8'd1;
          if (sq_nxt[0].en && swp_set_r[1:0] != 2'd0 &&
              swp_cnt_nxt == {5'd0, swp_set_r[5:3]}) begin
            d = sq_nxt[0].freq >> swp_set_r[1:0];
            if (swp_set_r[2]) f = {1'b0, sq_nxt[0].freq} - {1'b0, d};
            else f = {1'b0, sq_nxt[0].freq} + {1'b0, d};
            if (f[11]) begin
              sq_nxt[0].en = 1'b0;
              sq_nxt[0].trig = 1'b0;
            end
            sq_nxt[0].freq = f[10:0];
            swp_cnt_nxt = 8'd0;
          end
        end
        if (ea > ENV_PERIOD) begin
          ea = ea - ENV_PERIOD;
          for (int c = 0; c < 2; c++) begin
            sq_nxt[c].env_cnt = sq_nxt[c].env_cnt + 8'd1;
            if (sq_nxt[c].env_set[2:0] != 3'd0 &&
                sq_nxt[c].env_cnt == {5'd0, sq_nxt[c].env_set[2:0]}) begin
              if (sq_nxt[c].env_set[3] && sq_nxt[c].volume != 4'd15)
                sq_nxt[c].volume = sq_nxt[c].volume + 4'd1;
              else if (!sq_nxt[c].env_set[3] && sq_nxt[c].volume != 4'd0)
                sq_nxt[c].volume = sq_nxt[c].volume - 4'd1;
              sq_nxt[c].env_cnt = 8'd0;
            end
          end
        end
        if (la >= LEN_PERIOD) begin
          la = la - LEN_PERIOD;
          for (int c = 0; c < 2; c++) begin
            if (sq_nxt[c].cnt && sq_nxt[c].length != 7'd0) begin
              sq_nxt[c].length = sq_nxt[c].length - 7'd1;
              if (sq_nxt[c].length == 7'd0) sq_nxt[c].en = 1'b0;
            end
          end
        end
        len_acc_nxt = la[12:0];
        swp_acc_nxt = sa[13:0];
        env_acc_nxt = ea[14:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_acc_r    <= '0;
      swp_acc_r    <= '0;
      env_acc_r    <= '0;
      swp_set_r    <= '0;
      swp_cnt_r    <= '0;
      sq_r[0]      <= '0;
      sq_r[1]      <= '0;
      wave_regs_r  <= '0;
      noise_regs_r <= '0;
      mix_r        <= '0;
    end else if (go) begin
      len_acc_r    <= len_acc_nxt;
      swp_acc_r    <= swp_acc_nxt;
      env_acc_r    <= env_acc_nxt;
      swp_set_r    <= swp_set_nxt;
      swp_cnt_r    <= swp_cnt_nxt;
      sq_r[0]      <= sq_nxt[0];
      sq_r[1]      <= sq_nxt[1];
      wave_regs_r  <= wave_regs_nxt;
      noise_regs_r <= noise_regs_nxt;
      mix_r        <= mix_nxt;
    end
  end

  // Wave bytes reset to zero; all WAVE_BYTES entries are cleared directly by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WAVE_BYTES; i++) wave_mem_r[i] <= 8'd0;
    end else if (go && item.cmd == CMD_WRITE && in_wave) begin
      wave_mem_r[wave_idx] <= item.wdata;
    end
  end

  always_comb begin
    res.rdata      = rd;
    res.ch1_active = mix_nxt[16] && sq_nxt[0].en && (sq_nxt[0].freq != 11'd0);
    res.ch1_freq   = sq_nxt[0].freq;
    res.ch1_volume = sq_nxt[0].volume;
    res.ch1_duty   = sq_nxt[0].duty;
    res.ch2_active = mix_nxt[16] && sq_nxt[1].en && (sq_nxt[1].freq != 11'd0);
    res.ch2_freq   = sq_nxt[1].freq;
    res.ch2_volume = sq_nxt[1].volume;
    res.ch2_duty   = sq_nxt[1].duty;
  end

endmodule

FILE: test/sscr_checker.sv
// Result predictor and scoreboard for the square sound channel register block.
`timescale 1ns / 100ps
module sscr_checker
  import sscr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_wdata,
  input  logic [9:0]  in_clocks,
  input  logic        out_valid,
  input  logic        out_ready,
  input  res_t        out_res,
  output int          mismatches,
  output int          outstanding
);

  // Own copy of the register state.
  int unsigned len_acc, sweep_acc, env_acc;
  logic [5:0]  sweep_set;
  logic [7:0]  sweep_cnt;
  sq_t         sq [2];
  logic [23:0] wave_regs, noise_regs;
  logic [16:0] mixer;
  logic [7:0]  wave_mem [16];
  res_t        status_q[$];

  function automatic void envelope_tick(int c);
    sq[c].env_cnt = sq[c].env_cnt + 8'd1;
    if (sq[c].env_set[2:0] != 3'd0 && {5'd0, sq[c].env_set[2:0]} == sq[c].env_cnt) begin
      if (sq[c].env_set[3] && sq[c].volume < 4'd15) sq[c].volume++;
      else if (!sq[c].env_set[3] && sq[c].volume > 4'd0) sq[c].volume--;
      sq[c].env_cnt = 8'd0;
    end
  endfunction

  function automatic void length_tick(int c);
    if (sq[c].cnt && sq[c].length > 7'd0) begin
      sq[c].length--;
      if (sq[c].length == 7'd0) sq[c].en = 1'b0;
    end
  endfunction

  function automatic void advance_time(int unsigned n);
    logic [11:0] f, d;
    len_acc += n;
    sweep_acc += n;
    env_acc += n;
    for (int c = 0; c < 2; c++) begin
      if (!sq[c].en && sq[c].trig) begin
        sq[c].en = 1'b1;
        sq[c].trig = 1'b0;
      end
    end
    if (sweep_acc >= 8192) begin
      sweep_acc -= 8192;
      sweep_cnt = sweep_cnt + 8'd1;
      if (sq[0].en && sweep_set[1:0] != 2'd0 && sweep_cnt == {5'd0, sweep_set[5:3]}) begin
        f = {1'b0, sq[0].freq};
        d = f >> sweep_set[1:0];
        f = sweep_set[2] ? f - d : f + d;
        if (f > 12'd2047) begin
          sq[0].en = 1'b0;
          sq[0].trig = 1'b0;
        end
        sq[0].freq = f[10:0];
        sweep_cnt = 8'd0;
      end
    end
    if (env_acc > 16384) begin
      env_acc -= 16384;
      envelope_tick(0);
      envelope_tick(1);
    end
    if (len_acc >= 4096) begin
      len_acc -= 4096;
      length_tick(0);
      length_tick(1);
    end
  endfunction

  function automatic void store_byte(logic [15:0] a, logic [7:0] b);
    int c;
    case (a)
      A_NR10: begin
        sweep_set = {b[6:4], b[3], b[1:0]};
        sweep_cnt = 8'd0;
      end
      A_NR11, A_NR21: begin
        c = (a == A_NR11) ? 0 : 1;
        sq[c].length = {1'b0, b[5:0]};
        sq[c].duty = b[7:6];
      end
      A_NR12, A_NR22: begin
        c = (a == A_NR12) ? 0 : 1;
        sq[c].env_set = b;
        sq[c].env_cnt = 8'd0;
      end
      A_NR13: sq[0].freq[7:0] = b;
      A_NR23: sq[1].freq[7:0] = b;
      A_NR14, A_NR24: begin
        c = (a == A_NR14) ? 0 : 1;
        sq[c].freq[10:8] = b[2:0];
        sq[c].cnt = b[6];
        sq[c].trig = 1'b0;
        if (b[7]) begin
          sq[c].trig = 1'b1;
          sq[c].en = 1'b1;
          if (sq[c].length == 7'd0) sq[c].length = 7'd64;
          sq[c].volume = sq[c].env_set[7:4];
          sq[c].env_cnt = 8'd0;
        end
      end
      A_NR30: wave_regs[0] = b[7];
      A_NR31: wave_regs[8:1] = b;
      A_NR32: wave_regs[10:9] = b[6:5];
      A_NR33: wave_regs[18:11] = b;
      A_NR34: wave_regs[23:19] = {b[7], b[6], b[2:0]};
      A_NR41: noise_regs[5:0] = b[5:0];
      A_NR42: noise_regs[13:6] = b;
      A_NR43: noise_regs[21:14] = b;
      A_NR44: noise_regs[23:22] = b[7:6];
      A_NR50: mixer[7:0] = b;
      A_NR51: mixer[15:8] = b;
      A_NR52: mixer[16] = b[7];
      default: if (a >= A_WAVE && a < A_WAVE + 16) wave_mem[a - A_WAVE] = b;
    endcase
  endfunction

  function automatic logic [7:0] fetch_byte(logic [15:0] a);
    case (a)
      A_NR10: return {1'b0, sweep_set[5:3], sweep_set[2], 1'b0, sweep_set[1:0]};
      A_NR11: return {sq[0].duty, 6'd0};
      A_NR21: return {sq[1].duty, 6'd0};
      A_NR12: return sq[0].env_set;
      A_NR22: return sq[1].env_set;
      A_NR13: return sq[0].freq[7:0];
      A_NR23: return sq[1].freq[7:0];
      A_NR14: return {1'b0, sq[0].cnt, 6'd0};
      A_NR24: return {1'b0, sq[1].cnt, 6'd0};
      A_NR30: return {wave_regs[0], 7'd0};
      A_NR31: return wave_regs[8:1];
      A_NR32: return {1'b0, wave_regs[10:9], 5'd0};
      A_NR33: return wave_regs[18:11];
      A_NR34: return {1'b0, wave_regs[22], 6'd0};
      A_NR41: return {2'd0, noise_regs[5:0]};
      A_NR42: return noise_regs[13:6];
      A_NR43: return noise_regs[21:14];
      A_NR44: return {1'b0, noise_regs[22], 6'd0};
      A_NR50: return mixer[7:0];
      A_NR51: return mixer[15:8];
      A_NR52: return {mixer[16], 5'd0, sq[1].en, sq[0].en};
      default: begin
        if (a >= A_WAVE && a < A_WAVE + 16) return wave_mem[a - A_WAVE];
        return 8'd0;
      end
    endcase
  endfunction

  function automatic res_t predict_status(logic [1:0] cmd, logic [15:0] a,
                                          logic [7:0] b, logic [9:0] n);
    res_t r;
    r = '0;
    case (cmd)
      CMD_WRITE: store_byte(a, b);
      CMD_READ:  r.rdata = fetch_byte(a);
      CMD_TICK:  advance_time(n);
      default: ;
    endcase
    r.ch1_active = mixer[16] && sq[0].en && sq[0].freq != 11'd0;
    r.ch1_freq   = sq[0].freq;
    r.ch1_volume = sq[0].volume;
    r.ch1_duty   = sq[0].duty;
    r.ch2_active = mixer[16] && sq[1].en && sq[1].freq != 11'd0;
    r.ch2_freq   = sq[1].freq;
    r.ch2_volume = sq[1].volume;
    r.ch2_duty   = sq[1].duty;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      len_acc = 0; sweep_acc = 0; env_acc = 0;
      sweep_set = '0; sweep_cnt = '0;
      sq[0] = '0; sq[1] = '0;
      wave_regs = '0; noise_regs = '0; mixer = '0;
      for (int i = 0; i < 16; i++) wave_mem[i] = 8'd0;
      status_q.delete();
      mismatches = 0;
    end else begin
      if (in_valid && in_ready)
        status_q.push_back(predict_status(in_cmd, in_addr, in_wdata, in_clocks));
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", out_res);
        end else begin
          want = status_q.pop_front();
          if (out_res !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch at %0t\n  expected %p\n  actual   %p",
                       $realtime, want, out_res);
          end
        end
      end
    end
    outstanding = status_q.size();
  end

endmodule

FILE: test/tb.sv
// Top level of the square sound channel register testbench: stimulus and verdict.
`timescale 1ns / 100ps
module tb;
  import sscr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [15:0] in_addr;
  logic [7:0]  in_wdata;
  logic [9:0]  in_clocks;
  logic        out_valid;
  logic        out_ready;
  res_t        out_res;
  int          mismatches;
  int          outstanding;
  int          quiet_cycles;

  // The watchdog allows far more than the longest idle gap on either side.
  localparam int QUIET_LIMIT = 5000;

  square_sound_channel_registers dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_addr(in_addr), .in_wdata(in_wdata), .in_clocks(in_clocks),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_rdata(out_res.rdata),
    .out_ch1_active(out_res.ch1_active), .out_ch1_freq(out_res.ch1_freq),
    .out_ch1_volume(out_res.ch1_volume), .out_ch1_duty(out_res.ch1_duty),
    .out_ch2_active(out_res.ch2_active), .out_ch2_freq(out_res.ch2_freq),
    .out_ch2_volume(out_res.ch2_volume), .out_ch2_duty(out_res.ch2_duty)
  );

  sscr_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_addr(in_addr), .in_wdata(in_wdata), .in_clocks(in_clocks),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(out_res),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Most idle gaps are drawn from the short range, now and then from a long one.
  // At random intervals a burst mode may turn gaps off entirely.
  bit burst_mode;

  function automatic int pick_gap();
    if (burst_mode) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  initial begin
    burst_mode = 1'b0;
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      burst_mode = ($urandom_range(0, 3) == 0);
    end
  end

  // The result side stalls with the same kind of gaps: hold ready low for a
  // chosen number of cycles, then high for a random stretch.
  initial begin
    int hold;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // The watchdog counts cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("square_sound_channel_registers regression: fail");
        $finish;
      end
    end
  end

  // Offer one item and hold it until the block takes it. Valid is only
  // lowered when a gap follows, so it never gets two assignments in a step.
  task automatic send_item(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data,
                           logic [9:0] ticks);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_addr   <= addr;
    in_wdata  <= data;
    in_clocks <= ticks;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic bus_write(logic [15:0] addr, logic [7:0] data);
    send_item(CMD_WRITE, addr, data, 10'($urandom));
  endtask

  task automatic bus_read(logic [15:0] addr);
    send_item(CMD_READ, addr, 8'($urandom), 10'($urandom));
  endtask

  task automatic time_tick(logic [9:0] ticks);
    send_item(CMD_TICK, 16'($urandom), 8'($urandom), ticks);
  endtask

  // Random addresses mostly land on the sound registers and wave bytes, with
  // the trigger and master registers weighted up so channels actually play.
  function automatic logic [15:0] pick_addr();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5)  return 16'($urandom);
    if (sel < 15) return A_NR14;
    if (sel < 25) return A_NR24;
    if (sel < 30) return A_NR52;
    if (sel < 40) return A_NR10;
    return A_NR10 + 16'($urandom_range(0, 16'h2F));
  endfunction

  // Trigger register writes set the trigger bit at least half of the time,
  // and the master switch is mostly left on.
  function automatic logic [7:0] pick_data(logic [15:0] addr);
    logic [7:0] b;
    b = 8'($urandom);
    if (addr == A_NR52 && $urandom_range(0, 3) != 0) b[7] = 1'b1;
    if ((addr == A_NR14 || addr == A_NR24) && $urandom_range(0, 1) == 1) b[7] = 1'b1;
    return b;
  endfunction

  initial begin
    int sel;
    logic [15:0] a;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_cmd    = CMD_WRITE;
    in_addr   = '0;
    in_wdata  = '0;
    in_clocks = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: master on, channel setup with field extremes, both
    // triggers, a sweep setup that adds to the top frequency, ticks that run the length timer,
    // the status read, wave length write, unmapped addresses and the unknown command.
    bus_write(A_NR52, 8'hFF);
    bus_write(A_NR10, 8'h71);
    bus_write(A_NR11, 8'hFF);
    bus_write(A_NR12, 8'hF7);
    bus_write(A_NR13, 8'hFF);
    bus_write(A_NR14, 8'hC7);
    bus_write(A_NR21, 8'h00);
    bus_write(A_NR22, 8'h09);
    bus_write(A_NR23, 8'h01);
    bus_write(A_NR24, 8'h80);
    bus_write(A_NR31, 8'hFF);
    bus_write(A_NR32, 8'h60);
    bus_write(A_WAVE + 16'd15, 8'hA5);
    bus_write(16'h0000, 8'hFF);
    bus_write(16'hFFFF, 8'hFF);
    send_item(CMD_NOP, A_NR52, 8'hFF, 10'h3FF);
    time_tick(10'd1023);
    time_tick(10'd0);
    repeat (9) time_tick(10'd1023);
    bus_read(A_NR52);
    bus_read(A_NR32);
    bus_read(A_WAVE + 16'd15);
    bus_read(16'hFFFF);

    // Random part: register traffic mixed with ticks, mostly large ones so
    // the frame timers fire often.
    for (int i = 0; i < 1300; i++) begin
      sel = $urandom_range(0, 99);
      a = pick_addr();
      if (sel < 40)      bus_write(a, pick_data(a));
      else if (sel < 65) bus_read(a);
      else if (sel < 97) time_tick($urandom_range(0, 3) == 0 ? 10'($urandom) :
                                   10'($urandom_range(700, 1023)));
      else               send_item(CMD_NOP, 16'($urandom), 8'($urandom), 10'($urandom));
    end
    in_valid <= 1'b0;

    // One more edge so the checker has counted the last accepted item.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("square_sound_channel_registers regression: pass");
    else
      $display("square_sound_channel_registers regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
design/sscr_pkg.sv
design/sscr_core.sv
design/square_sound_channel_registers.sv
test/sscr_checker.sv
test/tb.sv
